@@ rtl/core/bbt_pkg.sv @@
// bbt_pkg: widths, codes and reset values shared by the bar/beat/tick timebase
// depends on nothing; used by bbt_mul, bbt_div, the core top level and both testbench files
package bbt_pkg;

	// fractional tick bits of the fixed-point tick counts
	localparam int FRAC_BITS = 16;

	// field widths
	localparam int SR_W   = 18;
	localparam int TEMPO_W = 17;
	localparam int BPB_W  = 6;
	localparam int UNIT_W = 6;
	localparam int TPB_W  = 12;
	localparam int PF_W   = 14;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 3;
	localparam int FRAME_W = 32;
	localparam int BAR_W  = 24;
	localparam int BEAT_W = 6;
	localparam int TICK_W = 12;
	localparam int BST_W  = 48;

	// datapath widths
	localparam int PW    = PF_W + TEMPO_W + UNIT_W + TPB_W;   // widest product
	localparam int NW    = PW + FRAC_BITS;                     // dividend shifter
	localparam int DW    = 35;                                 // divisor / remainder
	localparam int BW    = BPB_W + TPB_W;                      // serial multiplier operand
	localparam int CW    = $clog2(NW + 1);
	localparam int PTW   = 24 + FRAC_BITS;                     // ticks per period
	localparam int TFW   = TICK_W + FRAC_BITS;                 // tick position
	localparam int SUMW  = PTW + 1;
	localparam int SUM_IW = SUMW - FRAC_BITS;
	localparam int TOT_W = SUM_IW + 1;

	// 24000 = 1500 * 2^PERIOD_SHIFT
	localparam int SR_SCALE     = 1500;
	localparam int PERIOD_SHIFT = 4;

	// register reset values
	localparam logic [SR_W-1:0]    SR_RST    = SR_W'(48000);
	localparam logic [TEMPO_W-1:0] TEMPO_RST = TEMPO_W'(12000);
	localparam logic [BPB_W-1:0]   BPB_RST   = BPB_W'(4);
	localparam logic [UNIT_W-1:0]  UNIT_RST  = UNIT_W'(4);
	localparam logic [TPB_W-1:0]   TPB_RST   = TPB_W'(1920);
	localparam logic [PF_W-1:0]    PF_RST    = PF_W'(1024);

	typedef enum logic [IDX_W-1:0] {
		REG_SAMPLE_RATE = 3'd0,
		REG_TEMPO       = 3'd1,
		REG_BPB         = 3'd2,
		REG_UNIT        = 3'd3,
		REG_TPB         = 3'd4,
		REG_PF          = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic          start;
		logic [CW-1:0] steps;
	} div_cmd_t;

endpackage

@@ rtl/core/bbt_mul.sv @@
// bbt_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on bbt_pkg
module bbt_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [bbt_pkg::PW-1:0] a,
	input  logic [bbt_pkg::BW-1:0] b,
	output logic                  busy,
	output logic [bbt_pkg::PW-1:0] prod
);

	logic [bbt_pkg::PW-1:0] a_q;
	logic [bbt_pkg::BW-1:0] b_q;
	logic [bbt_pkg::PW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q <= '0;
		end else if (start) begin
			b_q <= b;
		end else if (b_q != '0) begin
			b_q <= b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= '0;
		end else if (b_q != '0) begin
			a_q <= {a_q[bbt_pkg::PW-2:0], 1'b0};
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
		end
	end

	assign busy = (b_q != '0);
	assign prod = acc_q;

endmodule

@@ rtl/core/bbt_div.sv @@
// bbt_div: restoring divider, one quotient bit per cycle, steps set per command
// depends on bbt_pkg; dividend is given left-aligned in the shifter
module bbt_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bbt_pkg::div_cmd_t      cmd,
	input  logic [bbt_pkg::NW-1:0] dividend,
	input  logic [bbt_pkg::DW-1:0] divisor,
	output logic                   busy,
	output logic [bbt_pkg::NW-1:0] quot,
	output logic [bbt_pkg::DW-1:0] rem
);

	logic [bbt_pkg::CW-1:0] count_q;
	logic [bbt_pkg::NW-1:0] n_q;
	logic [bbt_pkg::NW-1:0] q_q;
	logic [bbt_pkg::DW-1:0] d_q;
	logic [bbt_pkg::DW-1:0] r_q;
	logic [bbt_pkg::DW:0]   trial;
	logic [bbt_pkg::DW:0]   diff;
	logic                   ge;
	logic [bbt_pkg::DW-1:0] r_next;

	always_comb begin
		trial  = {r_q, n_q[bbt_pkg::NW-1]};
		diff   = trial - {1'b0, d_q};
		ge     = (trial >= {1'b0, d_q});
		r_next = ge ? diff[bbt_pkg::DW-1:0] : trial[bbt_pkg::DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.start) begin
			count_q <= cmd.steps;
		end else if (count_q != '0) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
			q_q <= '0;
		end else if (count_q != '0) begin
			n_q <= {n_q[bbt_pkg::NW-2:0], 1'b0};
			r_q <= r_next;
			q_q <= {q_q[bbt_pkg::NW-2:0], ge};
		end
	end

	assign busy = (count_q != '0);
	assign quot = q_q;
	assign rem  = r_q;

endmodule

@@ rtl/core/bar_beat_tick_transport_clock_core.sv @@
// bar_beat_tick_transport_clock_core: musical timebase master, sequencer and state
// depends on bbt_pkg, bbt_mul and bbt_div
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | new_position, frame
//  out     | out_valid / out_ready| bar, beat, tick, bar_origin_tick
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item at a time; a plain advance runs serial divides of 25 and 26 bits and a
// serial multiply of up to 18 bits, a recompute the whole micro-op sequence, both
// on the one-bit-per-cycle divider and multiplier.
// reset forces a recompute on the first item; so does any write to a known register index.
// register writes are taken only while the sequencer is idle.
// a finished result sits in the output register, and the next item is taken
// while it waits; the sequencer only stalls if a second result is ready first.
module bar_beat_tick_transport_clock_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        new_position,
	input  logic [bbt_pkg::FRAME_W-1:0] frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bbt_pkg::BAR_W-1:0]   bar,
	output logic [bbt_pkg::BEAT_W-1:0]  beat,
	output logic [bbt_pkg::TICK_W-1:0]  tick,
	output logic [bbt_pkg::BST_W-1:0]   bar_origin_tick,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bbt_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bbt_pkg::CFG_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	// micro-op sequence; recompute runs PF_TEMPO..BARSTART, advance ADV_*
	typedef enum logic [3:0] {
		OP_PF_TEMPO  = 4'd0,
		OP_MUL_UNIT  = 4'd1,
		OP_MUL_TPB   = 4'd2,
		OP_SR1500    = 4'd3,
		OP_BDEN      = 4'd4,
		OP_PERIOD    = 4'd5,
		OP_BNUM      = 4'd6,
		OP_WHOLE     = 4'd7,
		OP_REMTPB    = 4'd8,
		OP_TICK      = 4'd9,
		OP_BAR0      = 4'd10,
		OP_BT        = 4'd11,
		OP_BARSTART  = 4'd12,
		OP_ADV_BEATS = 4'd13,
		OP_ADV_BARS  = 4'd14,
		OP_ADV_MUL   = 4'd15
	} op_t;

	// configuration registers
	logic [bbt_pkg::SR_W-1:0]    sample_rate_q;
	logic [bbt_pkg::TEMPO_W-1:0] tempo_q;
	logic [bbt_pkg::BPB_W-1:0]   bpb_q;
	logic [bbt_pkg::UNIT_W-1:0]  unit_q;
	logic [bbt_pkg::TPB_W-1:0]   tpb_q;
	logic [bbt_pkg::PF_W-1:0]    pf_q;

	// sequencer and transport state
	state_t                      state_q;
	op_t                         op_q;
	logic                        recalc_q;
	logic [bbt_pkg::FRAME_W-1:0] frame_q;
	logic [bbt_pkg::BAR_W-1:0]   cur_bar_q;
	logic [bbt_pkg::BEAT_W-1:0]  cur_beat_q;
	logic [bbt_pkg::TFW-1:0]     tick_fixed_q;
	logic [bbt_pkg::PTW-1:0]     period_q;
	logic [bbt_pkg::BST_W-1:0]   bar_start_q;
	logic [bbt_pkg::BW-1:0]      bt_q;

	// scratch
	logic [bbt_pkg::PW-1:0] acc_q;
	logic [bbt_pkg::DW-1:0] s1500_q;
	logic [bbt_pkg::DW-1:0] bden_q;
	logic [bbt_pkg::PW-1:0] whole_q;

	// result register
	logic                       out_valid_q;
	logic [bbt_pkg::BAR_W-1:0]  bar_q;
	logic [bbt_pkg::BEAT_W-1:0] beat_q;
	logic [bbt_pkg::TICK_W-1:0] tick_q;
	logic [bbt_pkg::BST_W-1:0]  bst_q;

	// zero-as-one divisors
	logic [bbt_pkg::SR_W-1:0]  sr_nz;
	logic [bbt_pkg::BPB_W-1:0] bpb_nz;
	logic [bbt_pkg::UNIT_W-1:0] unit_nz;
	logic [bbt_pkg::TPB_W-1:0] tpb_nz;

	// unit hookup
	logic                   op_is_div;
	logic                   mul_start;
	logic                   mul_busy;
	logic [bbt_pkg::PW-1:0] mul_a;
	logic [bbt_pkg::BW-1:0] mul_b;
	logic [bbt_pkg::PW-1:0] mul_prod;
	bbt_pkg::div_cmd_t      div_cmd;
	logic                   div_busy;
	logic [bbt_pkg::NW-1:0] div_n;
	logic [bbt_pkg::DW-1:0] div_d;
	logic [bbt_pkg::CW-1:0] div_steps;
	logic [bbt_pkg::NW-1:0] div_quot;
	logic [bbt_pkg::DW-1:0] div_rem;
	logic                   unit_busy;

	// advance arithmetic
	logic [bbt_pkg::SUMW-1:0]  sum;
	logic [bbt_pkg::SUM_IW-1:0] sum_int;
	logic [bbt_pkg::TOT_W-1:0] total;
	logic                      period_sat;
	logic                      in_acc;

	// handshake helpers
	logic                      cfg_hit;
	logic                      recompute;
	logic                      out_load;

	assign sr_nz   = (sample_rate_q == '0) ? bbt_pkg::SR_W'(1) : sample_rate_q;
	assign bpb_nz  = (bpb_q == '0) ? bbt_pkg::BPB_W'(1) : bpb_q;
	assign unit_nz = (unit_q == '0) ? bbt_pkg::UNIT_W'(1) : unit_q;
	assign tpb_nz  = (tpb_q == '0) ? bbt_pkg::TPB_W'(1) : tpb_q;

	assign sum     = bbt_pkg::SUMW'(tick_fixed_q) + bbt_pkg::SUMW'(period_q);
	assign sum_int = sum[bbt_pkg::SUMW-1:bbt_pkg::FRAC_BITS];
	// beat index from zero plus whole beats just carried
	assign total   = bbt_pkg::TOT_W'(cur_beat_q) - bbt_pkg::TOT_W'(1)
		+ bbt_pkg::TOT_W'(div_quot[bbt_pkg::SUM_IW-1:0]);
	// integer part of ticks per period clamps at 24 bits
	assign period_sat = |div_quot[bbt_pkg::NW-1:bbt_pkg::PTW];

	// operand selection per micro-op
	always_comb begin
		op_is_div = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_n     = '0;
		div_d     = '0;
		div_steps = '0;
		unique case (op_q)
			OP_PF_TEMPO: begin
				mul_a = bbt_pkg::PW'(tempo_q);
				mul_b = bbt_pkg::BW'(pf_q);
			end
			OP_MUL_UNIT: begin
				mul_a = acc_q;
				mul_b = bbt_pkg::BW'(unit_nz);
			end
			OP_MUL_TPB: begin
				mul_a = acc_q;
				mul_b = bbt_pkg::BW'(tpb_nz);
			end
			OP_SR1500: begin
				mul_a = bbt_pkg::PW'(sr_nz);
				mul_b = bbt_pkg::BW'(bbt_pkg::SR_SCALE);
			end
			OP_BDEN: begin
				mul_a = bbt_pkg::PW'(s1500_q);
				mul_b = bbt_pkg::BW'(unit_nz);
			end
			OP_PERIOD: begin
				op_is_div = 1'b1;
				div_n     = {acc_q, {bbt_pkg::FRAC_BITS{1'b0}}};
				div_d     = bbt_pkg::DW'({s1500_q, {bbt_pkg::PERIOD_SHIFT{1'b0}}});
				div_steps = bbt_pkg::CW'(bbt_pkg::NW);
			end
			OP_BNUM: begin
				mul_a = bbt_pkg::PW'(frame_q);
				mul_b = bbt_pkg::BW'(tempo_q);
			end
			OP_WHOLE: begin
				op_is_div = 1'b1;
				div_n     = {acc_q, {bbt_pkg::FRAC_BITS{1'b0}}};
				div_d     = bden_q;
				div_steps = bbt_pkg::CW'(bbt_pkg::PW);
			end
			OP_REMTPB: begin
				mul_a = bbt_pkg::PW'(div_rem);
				mul_b = bbt_pkg::BW'(tpb_nz);
			end
			OP_TICK: begin
				op_is_div = 1'b1;
				div_n     = {acc_q, {bbt_pkg::FRAC_BITS{1'b0}}};
				div_d     = bden_q;
				div_steps = bbt_pkg::CW'(bbt_pkg::NW);
			end
			OP_BAR0: begin
				op_is_div = 1'b1;
				div_n     = {whole_q, {bbt_pkg::FRAC_BITS{1'b0}}};
				div_d     = bbt_pkg::DW'(bpb_nz);
				div_steps = bbt_pkg::CW'(bbt_pkg::PW);
			end
			OP_BT: begin
				mul_a = bbt_pkg::PW'(bpb_nz);
				mul_b = bbt_pkg::BW'(tpb_nz);
			end
			OP_BARSTART: begin
				mul_a = div_quot[bbt_pkg::PW-1:0];
				mul_b = bt_q;
			end
			OP_ADV_BEATS: begin
				op_is_div = 1'b1;
				div_n     = {sum_int, {(bbt_pkg::NW - bbt_pkg::SUM_IW){1'b0}}};
				div_d     = bbt_pkg::DW'(tpb_nz);
				div_steps = bbt_pkg::CW'(bbt_pkg::SUM_IW);
			end
			OP_ADV_BARS: begin
				op_is_div = 1'b1;
				div_n     = {total, {(bbt_pkg::NW - bbt_pkg::TOT_W){1'b0}}};
				div_d     = bbt_pkg::DW'(bpb_nz);
				div_steps = bbt_pkg::CW'(bbt_pkg::TOT_W);
			end
			OP_ADV_MUL: begin
				mul_a = bbt_pkg::PW'(div_quot[bbt_pkg::TOT_W-1:0]);
				mul_b = bt_q;
			end
			default: begin
				op_is_div = 1'b0;
			end
		endcase
	end

	assign mul_start     = (state_q == ST_ISSUE) && !op_is_div;
	assign div_cmd.start = (state_q == ST_ISSUE) && op_is_div;
	assign div_cmd.steps = div_steps;
	assign unit_busy     = op_is_div ? div_busy : mul_busy;

	bbt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	bbt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_n),
		.divisor  (div_d),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	// registers only change between items, never under a running sequence
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_hit   = cfg_valid && cfg_ready && (cfg_index <= bbt_pkg::REG_PF);
	// relocation, stale config or a known-index write on this very edge
	assign recompute = new_position || recalc_q || cfg_hit;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// register file; any known index forces a recompute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= bbt_pkg::SR_RST;
			tempo_q       <= bbt_pkg::TEMPO_RST;
			bpb_q         <= bbt_pkg::BPB_RST;
			unit_q        <= bbt_pkg::UNIT_RST;
			tpb_q         <= bbt_pkg::TPB_RST;
			pf_q          <= bbt_pkg::PF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bbt_pkg::REG_SAMPLE_RATE: sample_rate_q <= cfg_data[bbt_pkg::SR_W-1:0];
				bbt_pkg::REG_TEMPO:       tempo_q <= cfg_data[bbt_pkg::TEMPO_W-1:0];
				bbt_pkg::REG_BPB:         bpb_q   <= cfg_data[bbt_pkg::BPB_W-1:0];
				bbt_pkg::REG_UNIT:        unit_q  <= cfg_data[bbt_pkg::UNIT_W-1:0];
				bbt_pkg::REG_TPB:         tpb_q   <= cfg_data[bbt_pkg::TPB_W-1:0];
				bbt_pkg::REG_PF:          pf_q    <= cfg_data[bbt_pkg::PF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, transport state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_PF_TEMPO;
			recalc_q     <= 1'b1;
			out_valid_q  <= 1'b0;
			cur_bar_q    <= bbt_pkg::BAR_W'(1);
			cur_beat_q   <= bbt_pkg::BEAT_W'(1);
			tick_fixed_q <= '0;
			period_q     <= '0;
			bar_start_q  <= '0;
			bt_q         <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			// an accepted item always leaves with fresh state
			if (in_acc) begin
				recalc_q <= 1'b0;
			end else if (cfg_hit) begin
				recalc_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// relocation or stale config: full recompute from frame
						op_q    <= recompute ? OP_PF_TEMPO : OP_ADV_BEATS;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!unit_busy) begin
						state_q <= (op_q == OP_BARSTART || op_q == OP_ADV_MUL) ? ST_OUT
							: ST_ISSUE;
						op_q    <= op_t'(op_q + 1'b1);
						case (op_q)
							OP_PERIOD: begin
								period_q <= period_sat ? '1 : div_quot[bbt_pkg::PTW-1:0];
							end
							OP_TICK: begin
								tick_fixed_q <= div_quot[bbt_pkg::TFW-1:0];
							end
							OP_BAR0: begin
								cur_beat_q <= div_rem[bbt_pkg::BEAT_W-1:0] + 1'b1;
							end
							OP_BT: begin
								bt_q <= mul_prod[bbt_pkg::BW-1:0];
							end
							OP_BARSTART: begin
								bar_start_q <= mul_prod[bbt_pkg::BST_W-1:0];
								cur_bar_q   <= div_quot[bbt_pkg::BAR_W-1:0] + 1'b1;
							end
							OP_ADV_BEATS: begin
								tick_fixed_q <= {div_rem[bbt_pkg::TICK_W-1:0],
									sum[bbt_pkg::FRAC_BITS-1:0]};
							end
							OP_ADV_BARS: begin
								cur_beat_q <= div_rem[bbt_pkg::BEAT_W-1:0] + 1'b1;
							end
							OP_ADV_MUL: begin
								bar_start_q <= bar_start_q + mul_prod[bbt_pkg::BST_W-1:0];
								cur_bar_q   <= cur_bar_q + div_quot[bbt_pkg::BAR_W-1:0];
							end
							default: begin
							end
						endcase
					end
				end
				ST_OUT: begin
					// hold until the result register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath scratch and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			frame_q <= frame;
		end
		if (state_q == ST_WAIT && !unit_busy) begin
			case (op_q)
				OP_PF_TEMPO, OP_MUL_UNIT, OP_MUL_TPB, OP_BNUM, OP_REMTPB: begin
					acc_q <= mul_prod;
				end
				OP_SR1500: s1500_q <= mul_prod[bbt_pkg::DW-1:0];
				OP_BDEN:   bden_q  <= mul_prod[bbt_pkg::DW-1:0];
				OP_WHOLE:  whole_q <= div_quot[bbt_pkg::PW-1:0];
				default: begin
				end
			endcase
		end
		if (out_load) begin
			bar_q  <= cur_bar_q;
			beat_q <= cur_beat_q;
			tick_q <= tick_fixed_q[bbt_pkg::TFW-1:bbt_pkg::FRAC_BITS];
			bst_q  <= bar_start_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign bar             = bar_q;
	assign beat            = beat_q;
	assign tick            = tick_q;
	assign bar_origin_tick = bst_q;

endmodule

@@ tb/bar_beat_tick_transport_clock_core_chk.sv @@
// bar_beat_tick_transport_clock_core_chk: watches the three channels and predicts positions
// depends on bbt_pkg; compares every result item against its own bar/beat/tick predictor
`timescale 1ns / 100ps

module bar_beat_tick_transport_clock_core_chk
	import bbt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                new_position,
	input  logic [FRAME_W-1:0]  frame,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [BAR_W-1:0]    bar,
	input  logic [BEAT_W-1:0]   beat,
	input  logic [TICK_W-1:0]   tick,
	input  logic [BST_W-1:0]    bar_origin_tick,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  mismatches,
	output int                  positions_waiting,
	output int                  positions_seen,
	output int                  relocations
);

	typedef struct packed {
		logic [BAR_W-1:0]  bar;
		logic [BEAT_W-1:0] beat;
		logic [TICK_W-1:0] tick;
		logic [BST_W-1:0]  bst;
	} position_t;

	position_t position_q[$];

	logic [SR_W-1:0]    sr_r;
	logic [TEMPO_W-1:0] tempo_r;
	logic [BPB_W-1:0]   bpb_r;
	logic [UNIT_W-1:0]  unit_r;
	logic [TPB_W-1:0]   tpb_r;
	logic [PF_W-1:0]    pf_r;

	logic               resync;
	logic [BAR_W-1:0]   bar_now;
	logic [BEAT_W-1:0]  beat_now;
	logic [TFW-1:0]     tick_pos;
	logic [PTW-1:0]     period_step;
	logic [BST_W-1:0]   bar_origin;

	function automatic bit [63:0] at_least_one(bit [63:0] v);
		return (v == 0) ? 64'd1 : v;
	endfunction

	// floored num*2^F/den, integer part clamped to ibits
	function automatic bit [63:0] fixed_quotient(bit [63:0] num, bit [63:0] den, int ibits);
		bit [63:0] q;
		bit [63:0] r;
		bit [63:0] lim;
		q = num / den;
		r = num % den;
		lim = (64'd1 << ibits) - 1;
		if (q > lim)
			return (lim << FRAC_BITS) | ((64'd1 << FRAC_BITS) - 1);
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	task automatic advance_position(input logic relocate, input logic [FRAME_W-1:0] fr);
		bit [63:0] sr, tempo, bpb, unit, tpb, pf;
		bit [63:0] beat_den, beat_num, whole, rem, bar0;
		bit [63:0] sum, whole_ticks, frac, beats, total, bars;
		position_t p;
		sr = at_least_one(64'(sr_r));
		tempo = 64'(tempo_r);
		bpb = at_least_one(64'(bpb_r));
		unit = at_least_one(64'(unit_r));
		tpb = at_least_one(64'(tpb_r));
		pf = 64'(pf_r);
		if (relocate || resync) begin
			// exact position from the absolute frame
			beat_den = sr * 1500 * unit;
			beat_num = 64'(fr) * tempo;
			whole = beat_num / beat_den;
			rem = beat_num % beat_den;
			bar0 = whole / bpb;
			period_step = PTW'(fixed_quotient(pf * tempo * unit * tpb, sr * 24000, 24));
			beat_now = BEAT_W'(1 + whole % bpb);
			tick_pos = TFW'(fixed_quotient(rem * tpb, beat_den, TICK_W));
			bar_origin = BST_W'(bar0 * bpb * tpb);
			bar_now = BAR_W'(bar0 + 1);
			resync = 1'b0;
			relocations++;
		end else begin
			// accumulate fractional ticks, carry beats then bars
			sum = 64'(tick_pos) + 64'(period_step);
			whole_ticks = sum >> FRAC_BITS;
			frac = sum & ((64'd1 << FRAC_BITS) - 1);
			beats = whole_ticks / tpb;
			total = (64'(beat_now) - 1) + beats;
			bars = total / bpb;
			tick_pos = TFW'(((whole_ticks % tpb) << FRAC_BITS) | frac);
			beat_now = BEAT_W'(total % bpb + 1);
			bar_now = BAR_W'(64'(bar_now) + bars);
			bar_origin = BST_W'(64'(bar_origin) + bars * bpb * tpb);
		end
		p.bar = bar_now;
		p.beat = beat_now;
		p.tick = TICK_W'(tick_pos >> FRAC_BITS);
		p.bst = bar_origin;
		position_q.push_back(p);
	endtask

	initial begin
		mismatches = 0;
		positions_waiting = 0;
		positions_seen = 0;
		relocations = 0;
		sr_r = SR_RST;
		tempo_r = TEMPO_RST;
		bpb_r = BPB_RST;
		unit_r = UNIT_RST;
		tpb_r = TPB_RST;
		pf_r = PF_RST;
		resync = 1'b1;
		bar_now = BAR_W'(1);
		beat_now = BEAT_W'(1);
		tick_pos = '0;
		period_step = '0;
		bar_origin = '0;
	end

	always @(posedge clk) begin
		position_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLE_RATE: sr_r = SR_W'(cfg_data);
					REG_TEMPO:       tempo_r = TEMPO_W'(cfg_data);
					REG_BPB:         bpb_r = BPB_W'(cfg_data);
					REG_UNIT:        unit_r = UNIT_W'(cfg_data);
					REG_TPB:         tpb_r = TPB_W'(cfg_data);
					REG_PF:          pf_r = PF_W'(cfg_data);
					default:         ;
				endcase
				if (cfg_index <= REG_PF)
					resync = 1'b1;
			end
			if (in_valid && in_ready)
				advance_position(new_position, frame);
			if (out_valid && out_ready) begin
				positions_seen++;
				if (position_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result item with nothing expected", $realtime);
				end else begin
					want = position_q.pop_front();
					if (want.bar !== bar || want.beat !== beat || want.tick !== tick
							|| want.bst !== bar_origin_tick) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp bar %0d beat %0d tick %0d bst %0d, got %0d %0d %0d %0d",
								$realtime, want.bar, want.beat, want.tick, want.bst,
								bar, beat, tick, bar_origin_tick);
					end
				end
			end
			positions_waiting = position_q.size();
		end
	end

endmodule

@@ tb/bar_beat_tick_transport_clock_core_tb.sv @@
// bar_beat_tick_transport_clock_core_tb: stimulus and verdict for the timebase core
// depends on bbt_pkg, the core and bar_beat_tick_transport_clock_core_chk
`timescale 1ns / 100ps

module bar_beat_tick_transport_clock_core_tb;
	import bbt_pkg::*;

	localparam int       N_PHASES    = 8;
	localparam int       PER_PHASE   = 230;
	localparam longint   CYCLE_LIMIT = 6000000;
	localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd6;   // beyond the register list

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                new_position = 1'b0;
	logic [FRAME_W-1:0]  frame = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BAR_W-1:0]    bar;
	logic [BEAT_W-1:0]   beat;
	logic [TICK_W-1:0]   tick;
	logic [BST_W-1:0]    bar_origin_tick;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;

	int     mismatches, positions_waiting, positions_seen, relocations;
	int     stall_pct = 0;
	int     items_sent = 0;
	longint cycles = 0;

	// register settings per phase: rate, tempo, bpb, unit, tpb, period frames
	logic [CFG_W-1:0] setting [N_PHASES][6] = '{
		'{18'd48000,  18'd12000,  18'd4,  18'd4,  18'd1920, 18'd1024},  // reset values
		'{18'd8000,   18'd100,    18'd1,  18'd1,  18'd1,    18'd16},    // all low
		'{18'd192000, 18'd99900,  18'd32, 18'd32, 18'd3840, 18'd8192},  // all high
		'{18'd0,      18'd0,      18'd0,  18'd0,  18'd0,    18'd16},    // zero registers
		'{18'h3FFFF,  18'h3FFFF,  18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF},
		'{18'd1,      18'd99900,  18'd1,  18'd1,  18'd4095, 18'd8192},  // bar wrap
		'{18'd44100,  18'd14000,  18'd7,  18'd8,  18'd960,  18'd256},
		'{18'd1,      18'h1FFFF,  18'd63, 18'd63, 18'd4095, 18'h3FFF}   // saturating period
	};
	int stall_by_phase [N_PHASES] = '{0, 30, 70, 50, 10, 40, 85, 20};

	bar_beat_tick_transport_clock_core uut (.*);

	bar_beat_tick_transport_clock_core_chk chk (.*);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("bar_beat_tick_transport_clock_core_tb: errors");
			$finish;
		end
	end

	// receiver stalls at a per-phase rate
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// present one period item and hold it until taken
	task automatic send_period(input logic np, input logic [FRAME_W-1:0] fr);
		@(negedge clk);
		in_valid <= 1'b1;
		new_position <= np;
		frame <= fr;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic idle_sender(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender holds off until every position has come back
	task automatic drain;
		idle_sender(0);
		while (positions_waiting != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		logic [FRAME_W-1:0] run_frame;
		int burst;
		int gap;
		logic np;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: relocations and plain advances interleaved, at the frame extremes and in between
		send_period(1'b0, 32'd0);
		send_period(1'b0, 32'd1024);
		send_period(1'b1, 32'hFFFF_FFFF);
		send_period(1'b0, 32'd0);
		send_period(1'b1, 32'd0);
		send_period(1'b1, 32'h8000_0000);
		send_period(1'b0, 32'h1234_5678);
		send_period(1'b1, 32'h5555_5555);
		send_period(1'b1, 32'hAAAA_AAAA);
		send_period(1'b0, 32'hFFFF_FFFF);
		drain();
		// ignored write must not force a recompute
		write_reg(IDX_UNUSED, 18'h3FFFF);
		send_period(1'b0, 32'd7);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			drain();
			if (ph != 0) begin
				write_reg(REG_SAMPLE_RATE, setting[ph][0]);
				write_reg(REG_TEMPO,       setting[ph][1]);
				write_reg(REG_BPB,         setting[ph][2]);
				write_reg(REG_UNIT,        setting[ph][3]);
				write_reg(REG_TPB,         setting[ph][4]);
				write_reg(REG_PF,          setting[ph][5]);
			end
			stall_pct = stall_by_phase[ph];
			run_frame = $urandom;
			burst = 0;
			for (int i = 0; i < PER_PHASE; i++) begin
				if (i == PER_PHASE / 2)
					drain();
				if (burst == 0) begin
					burst = $urandom_range(1, 24);
					// some bursts run back to back with no gap at all
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					if (gap != 0)
						idle_sender(gap);
				end
				burst--;
				// mostly contiguous transport, sometimes a jump or relocation
				np = ($urandom_range(0, 11) == 0);
				if (np || $urandom_range(0, 15) == 0)
					run_frame = $urandom;
				else
					run_frame = run_frame + FRAME_W'(setting[ph][5]);
				send_period(np, run_frame);
			end
		end

		idle_sender(0);
		while (positions_waiting != 0) @(posedge clk);
		repeat (600) @(posedge clk);

		$display("%0d period items sent over %0d register settings, %0d positions checked",
			items_sent, N_PHASES, positions_seen);
		$display("%0d recomputes from the absolute frame, %0d mismatches",
			relocations, mismatches);
		if (mismatches == 0 && positions_waiting == 0)
			$display("bar_beat_tick_transport_clock_core_tb: clean");
		else
			$display("bar_beat_tick_transport_clock_core_tb: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/bbt_pkg.sv
rtl/core/bbt_mul.sv
rtl/core/bbt_div.sv
rtl/core/bar_beat_tick_transport_clock_core.sv
tb/bar_beat_tick_transport_clock_core_chk.sv
tb/bar_beat_tick_transport_clock_core_tb.sv
